/* hw/rtl/ddn_pkg.sv */
// Package for the date day number unit: shared types, calendar constants,
// operation codes and month and year length functions.
// No dependencies.
`default_nettype none

package ddn_pkg;

	// Year offset from 1900; a normalized year always fits in 0..199.
	typedef logic [7:0]         yoff_t;
	// Working value of the shared adder: wide enough for day number plus offset.
	typedef logic signed [20:0] acc_t;

	localparam logic [11:0] YEAR_FIRST = 12'd1900;
	localparam logic [11:0] YEAR_END   = 12'd2099;
	localparam acc_t        LAST_DAY   = 21'sd73049;
	localparam logic [8:0]  YEAR_SHORT = 9'd365;
	localparam logic [8:0]  YEAR_LONG  = 9'd366;

	// Operation codes on the func field.
	localparam logic [2:0] F_TO_NUM  = 3'd0;
	localparam logic [2:0] F_TO_DATE = 3'd1;
	localparam logic [2:0] F_ADD     = 3'd2;
	localparam logic [2:0] F_SUB     = 3'd3;
	localparam logic [2:0] F_DIFF    = 3'd4;
	localparam logic [2:0] F_INC     = 3'd5;
	localparam logic [2:0] F_DEC     = 3'd6;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_NUM_MON,
		S_NUM_YR,
		S_OFFS,
		S_WRAP,
		S_MODCHK,
		S_MOD,
		S_DATE_CHK,
		S_DATE_YR,
		S_DATE_MON,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} seq_stat_t;

	typedef struct packed {
		yoff_t              yoff;
		logic [3:0]         month;
		logic [4:0]         day;
		logic signed [17:0] number;
	} seq_res_t;

	// Within 1900..2099 a year is leap when divisible by four, except 1900.
	function automatic logic is_leap(input yoff_t yoff);
		return (yoff[1:0] == 2'b00) && (yoff != 8'd0);
	endfunction

	function automatic logic [4:0] month_days(input yoff_t yoff, input logic [3:0] month);
		logic [4:0] n;
		case (month)
			4'd2: begin
				n = is_leap(yoff) ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				n = 5'd30;
			end
			default: begin
				n = 5'd31;
			end
		endcase
		return n;
	endfunction

	function automatic logic [8:0] year_days(input yoff_t yoff);
		return is_leap(yoff) ? YEAR_LONG : YEAR_SHORT;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/ddn_norm.sv */
// Date normalizer: forces an out-of-range year, month or day to its first value
// and returns the year as an offset from 1900. Depends on ddn_pkg.
`default_nettype none

module ddn_norm
	import ddn_pkg::*;
(
	input  wire logic [11:0] year,
	input  wire logic [3:0]  month,
	input  wire logic [4:0]  day,
	output yoff_t            yoff,
	output logic [3:0]       month_n,
	output logic [4:0]       day_n
);

	logic       year_ok;
	yoff_t      year_rel;
	logic [4:0] dim;

	assign year_ok  = (year >= YEAR_FIRST) && (year <= YEAR_END);
	// Only the low byte matters once the year is known to be in range.
	assign year_rel = 8'(year - YEAR_FIRST);
	assign yoff     = year_ok ? year_rel : 8'd0;
	assign month_n  = ((month >= 4'd1) && (month <= 4'd12)) ? month : 4'd1;
	assign dim      = month_days(yoff, month_n);
	assign day_n    = ((day != 5'd0) && (day <= dim)) ? day : 5'd1;

endmodule

`default_nettype wire

/* hw/rtl/ddn_alu.sv */
// Shared add/subtract unit of the date sequencer; all day-count arithmetic of a
// conversion passes through it. Depends on ddn_pkg.
`default_nettype none

module ddn_alu
	import ddn_pkg::*;
(
	input  wire acc_t  a,
	input  wire acc_t  b,
	input  wire logic  sub,
	output acc_t       sum
);

	// One adder: a subtraction adds the inverted operand with a carry in.
	assign sum = a + (b ^ {21{sub}}) + {20'd0, sub};

endmodule

`default_nettype wire

/* hw/rtl/ddn_seq.sv */
// Sequencer of the date unit: walks months and years one step a cycle through
// the shared adder. Depends on ddn_pkg and ddn_alu.
`default_nettype none

module ddn_seq
	import ddn_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               out_free,
	input  wire logic [2:0]         func,
	input  wire logic signed [19:0] amount,
	input  wire yoff_t              ya,
	input  wire logic [3:0]         ma,
	input  wire logic [4:0]         da,
	input  wire yoff_t              yb,
	input  wire logic [3:0]         mb,
	input  wire logic [4:0]         db,
	output seq_stat_t               stat,
	output seq_res_t                res
);

	seq_state_t state_q, state_d;
	logic       pass_b_q, pass_b_d;
	acc_t       acc_q, acc_d;
	acc_t       num_a_q, num_a_d;
	yoff_t      yr_q, yr_d;
	logic [3:0] mo_q, mo_d;
	seq_res_t   res_q, res_d;

	acc_t       alu_a, alu_b, sum;
	logic       alu_sub;
	logic       sum_pos;
	yoff_t      ty;
	logic [3:0] tm;
	logic [4:0] td;
	seq_res_t   res_a;

	ddn_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.sum (sum)
	);

	assign sum_pos = !sum[20] && (sum != 21'sd0);

	// The second pass of a difference converts date b.
	assign ty = pass_b_q ? yb : ya;
	assign tm = pass_b_q ? mb : ma;
	assign td = pass_b_q ? db : da;

	// Result that leaves the first date as it stands, with its day number.
	always_comb begin
		res_a.yoff   = ya;
		res_a.month  = ma;
		res_a.day    = da;
		res_a.number = acc_q[17:0];
	end

	always_comb begin
		state_d  = state_q;
		pass_b_d = pass_b_q;
		acc_d    = acc_q;
		num_a_d  = num_a_q;
		yr_d     = yr_q;
		mo_d     = mo_q;
		res_d    = res_q;
		alu_a    = acc_q;
		alu_b    = 21'sd0;
		alu_sub  = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					pass_b_d = 1'b0;
					state_d  = S_LOAD;
				end
			end
			S_LOAD: begin
				if (func == F_TO_DATE) begin
					acc_d   = {amount[19], amount};
					state_d = S_DATE_CHK;
				end else begin
					acc_d   = {16'd0, td};
					yr_d    = 8'd0;
					mo_d    = 4'd1;
					state_d = S_NUM_MON;
				end
			end
			S_NUM_MON: begin
				if (mo_q < tm) begin
					alu_b = {16'd0, month_days(ty, mo_q)};
					acc_d = sum;
					mo_d  = mo_q + 4'd1;
				end else begin
					state_d = S_NUM_YR;
				end
			end
			S_NUM_YR: begin
				if (yr_q < ty) begin
					alu_b = {12'd0, year_days(yr_q)};
					acc_d = sum;
					yr_d  = yr_q + 8'd1;
				end else if (pass_b_q) begin
					alu_a        = num_a_q;
					alu_b        = acc_q;
					alu_sub      = 1'b1;
					res_d        = res_a;
					res_d.number = sum[17:0];
					state_d      = S_DONE;
				end else begin
					num_a_d = acc_q;
					case (func)
						F_DIFF: begin
							pass_b_d = 1'b1;
							state_d  = S_LOAD;
						end
						F_ADD, F_SUB, F_INC, F_DEC: begin
							state_d = S_OFFS;
						end
						default: begin
							res_d   = res_a;
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_OFFS: begin
				case (func)
					F_ADD: begin
						alu_b   = {amount[19], amount};
						acc_d   = sum;
						state_d = S_WRAP;
					end
					F_SUB: begin
						alu_b   = {amount[19], amount};
						alu_sub = 1'b1;
						acc_d   = sum;
						state_d = S_WRAP;
					end
					F_INC: begin
						if (acc_q != LAST_DAY) begin
							alu_b   = 21'sd1;
							acc_d   = sum;
							state_d = S_DATE_CHK;
						end else begin
							res_d   = res_a;
							state_d = S_DONE;
						end
					end
					F_DEC: begin
						if (acc_q != 21'sd1) begin
							alu_b   = 21'sd1;
							alu_sub = 1'b1;
							acc_d   = sum;
							state_d = S_DATE_CHK;
						end else begin
							res_d   = res_a;
							state_d = S_DONE;
						end
					end
					default: begin
						res_d   = res_a;
						state_d = S_DONE;
					end
				endcase
			end
			S_WRAP: begin
				// A negative sum is subtracted from the last day; a difference
				// at or below zero wraps forward by one span.
				if (func == F_ADD) begin
					if (acc_q[20]) begin
						alu_a   = LAST_DAY;
						alu_b   = acc_q;
						alu_sub = 1'b1;
						acc_d   = sum;
					end
				end else begin
					if (acc_q[20] || (acc_q == 21'sd0)) begin
						alu_b = LAST_DAY;
						acc_d = sum;
					end
				end
				state_d = S_MODCHK;
			end
			S_MODCHK: begin
				alu_b   = LAST_DAY;
				alu_sub = 1'b1;
				if (sum_pos) begin
					acc_d   = sum;
					state_d = S_MOD;
				end else begin
					state_d = S_DATE_CHK;
				end
			end
			S_MOD: begin
				// Once above the last day the value is reduced to a true
				// remainder, so an exact multiple ends at zero.
				alu_b   = LAST_DAY;
				alu_sub = 1'b1;
				if (!sum[20]) begin
					acc_d = sum;
				end else begin
					state_d = S_DATE_CHK;
				end
			end
			S_DATE_CHK: begin
				alu_b   = LAST_DAY;
				alu_sub = 1'b1;
				if (acc_q[20] || (acc_q == 21'sd0) || (acc_q == 21'sd1) || sum_pos) begin
					res_d.yoff   = 8'd0;
					res_d.month  = 4'd1;
					res_d.day    = 5'd1;
					res_d.number = 18'sd1;
					state_d      = S_DONE;
				end else begin
					res_d.number = acc_q[17:0];
					yr_d         = 8'd0;
					mo_d         = 4'd1;
					state_d      = S_DATE_YR;
				end
			end
			S_DATE_YR: begin
				alu_b   = {12'd0, year_days(yr_q)};
				alu_sub = 1'b1;
				if (sum_pos) begin
					acc_d = sum;
					yr_d  = yr_q + 8'd1;
				end else begin
					state_d = S_DATE_MON;
				end
			end
			S_DATE_MON: begin
				alu_b   = {16'd0, month_days(yr_q, mo_q)};
				alu_sub = 1'b1;
				if ((mo_q < 4'd12) && sum_pos) begin
					acc_d = sum;
					mo_d  = mo_q + 4'd1;
				end else begin
					res_d.yoff  = yr_q;
					res_d.month = mo_q;
					res_d.day   = acc_q[4:0];
					state_d     = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pass_b_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			pass_b_q <= pass_b_d;
		end
	end

	always_ff @(posedge clk) begin
		acc_q   <= acc_d;
		num_a_q <= num_a_d;
		yr_q    <= yr_d;
		mo_q    <= mo_d;
		res_q   <= res_d;
	end

	assign stat.busy = (state_q != S_IDLE);
	assign stat.done = (state_q == S_DONE);
	assign res       = res_q;

endmodule

`default_nettype wire

/* hw/rtl/date_day_number_unit.sv */
// Top level of the Gregorian date unit (1900-01-01 is day 1, 2099-12-31 day 73049):
// input capture, normalizers, sequencer and output register.
// Depends on ddn_pkg, ddn_norm and ddn_seq.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_stall   func, year_a, month_a, day_a, year_b, month_b,
//                                  day_b, amount
//   output   out_valid / out_stall res_year, res_month, res_day, number
//
// Each word is handled alone. Converting a date to a day number takes one step per
// month and per year from 1900; a difference does it twice.
// Add and subtract follow with up to nine reduction steps and a year and month walk
// back to a date, all through the single shared adder.
// in_stall is high from acceptance until the result moves to the output register.
// A finished word waits in the output register while out_stall is high; the next
// input word is taken meanwhile. Reset clears control state only.
`default_nettype none

module date_day_number_unit
	import ddn_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         func,
	input  wire logic [11:0]        year_a,
	input  wire logic [3:0]         month_a,
	input  wire logic [4:0]         day_a,
	input  wire logic [11:0]        year_b,
	input  wire logic [3:0]         month_b,
	input  wire logic [4:0]         day_b,
	input  wire logic signed [19:0] amount,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [11:0]             res_year,
	output logic [3:0]              res_month,
	output logic [4:0]              res_day,
	output logic signed [17:0]      number
);

	logic               in_acc;
	logic               out_free;
	logic               out_valid_q;
	logic [2:0]         func_q;
	logic [11:0]        year_a_q, year_b_q;
	logic [3:0]         month_a_q, month_b_q;
	logic [4:0]         day_a_q, day_b_q;
	logic signed [19:0] amount_q;
	yoff_t              ya, yb;
	logic [3:0]         ma, mb;
	logic [4:0]         da, db;
	seq_stat_t          stat;
	seq_res_t           res;
	logic [11:0]        res_year_q;
	logic [3:0]         res_month_q;
	logic [4:0]         res_day_q;
	logic signed [17:0] number_q;

	assign in_stall = stat.busy;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q    <= func;
			year_a_q  <= year_a;
			month_a_q <= month_a;
			day_a_q   <= day_a;
			year_b_q  <= year_b;
			month_b_q <= month_b;
			day_b_q   <= day_b;
			amount_q  <= amount;
		end
	end

	ddn_norm u_norm_a (
		.year    (year_a_q),
		.month   (month_a_q),
		.day     (day_a_q),
		.yoff    (ya),
		.month_n (ma),
		.day_n   (da)
	);

	ddn_norm u_norm_b (
		.year    (year_b_q),
		.month   (month_b_q),
		.day     (day_b_q),
		.yoff    (yb),
		.month_n (mb),
		.day_n   (db)
	);

	ddn_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_acc),
		.out_free (out_free),
		.func     (func_q),
		.amount   (amount_q),
		.ya       (ya),
		.ma       (ma),
		.da       (da),
		.yb       (yb),
		.mb       (mb),
		.db       (db),
		.stat     (stat),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && out_free) begin
			res_year_q  <= YEAR_FIRST + {4'd0, res.yoff};
			res_month_q <= res.month;
			res_day_q   <= res.day;
			number_q    <= res.number;
		end
	end

	assign out_valid = out_valid_q;
	assign res_year  = res_year_q;
	assign res_month = res_month_q;
	assign res_day   = res_day_q;
	assign number    = number_q;

endmodule

`default_nettype wire
